FILE: rtl/psu_pkg.sv
// Shared types, codes and helper functions for the PNG scanline unfilter.
// No dependencies; every other file in rtl/ imports this package.
package psu_pkg;

   // Filter type codes carried in the first byte of each row
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_kind_type;

   // Configuration register indexes
   localparam logic [0:0] CSR_BPP     = 1'b0;
   localparam logic [0:0] CSR_ROW_LEN = 1'b1;

   localparam int BPP_REG_W   = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int QUEUE_DEPTH = 4;

   // One classified pixel request handed from the front end to the back end
   typedef struct packed {
      logic [7:0]      data;
      filter_kind_type kind;
      logic            first_row;
      logic            failed;
      logic            last;
   } psu_item_type;

   function automatic logic [7:0] avg_pick(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[8:1];
   endfunction

   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [9:0] pa_s;
      logic signed [9:0] pb_s;
      logic signed [9:0] pc_s;
      logic [9:0]        pa;
      logic [9:0]        pb;
      logic [9:0]        pc;
      logic [7:0]        pick;
      pa_s = $signed({2'b00, b}) - $signed({2'b00, c});
      pb_s = $signed({2'b00, a}) - $signed({2'b00, c});
      pc_s = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
      pa = pa_s[9] ? 10'(-pa_s) : 10'(pa_s);
      pb = pb_s[9] ? 10'(-pb_s) : 10'(pb_s);
      pc = pc_s[9] ? 10'(-pc_s) : 10'(pc_s);
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

FILE: rtl/psu_front.sv
// Front end of the unfilter: accepts requests, tracks row position and filter.
// Depends on psu_pkg; pushes pixel requests into psu_fifo.
module psu_front
   import psu_pkg::*;
#(
   parameter int LEN_W  = 13,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_start_of_image,
   input  logic [LEN_W-1:0]  len_eff,
   input  logic              q_full,
   output logic              q_push,
   output logic [ADDR_W-1:0] q_x,
   output psu_item_type      q_item
);

   logic [LEN_W-1:0] column_ff, column_in;
   logic             first_ff, first_in;
   logic             failed_ff, failed_in;
   filter_kind_type  kind_ff, kind_in;

   logic             accept;
   logic [LEN_W-1:0] col_cur;
   logic             first_cur;
   logic             failed_cur;
   logic             is_last;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      // start of image restarts row tracking on this very byte
      col_cur    = req_start_of_image ? '0 : column_ff;
      first_cur  = req_start_of_image | first_ff;
      failed_cur = !req_start_of_image & failed_ff;
      is_last    = col_cur >= len_eff;

      column_in = column_ff;
      first_in  = first_ff;
      failed_in = failed_ff;
      kind_in   = kind_ff;
      q_push    = 1'b0;

      q_x              = ADDR_W'(col_cur - 1'b1);
      q_item.data      = req_data_byte;
      q_item.kind      = kind_ff;
      q_item.first_row = first_cur;
      q_item.failed    = failed_cur;
      q_item.last      = is_last;

      if (accept) begin
         failed_in = failed_cur;
         first_in  = first_cur;
         if (col_cur == '0) begin
            // filter byte: latch the kind or flag it, then drop it
            column_in = LEN_W'(1);
            if (req_data_byte > 8'(FILT_PAETH)) begin
               failed_in = 1'b1;
            end else begin
               kind_in = filter_kind_type'(req_data_byte[2:0]);
            end
         end else begin
            q_push = 1'b1;
            if (is_last) begin
               column_in = '0;
               first_in  = 1'b0;
            end else begin
               column_in = col_cur + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         first_ff  <= 1'b1;
         failed_ff <= 1'b0;
         kind_ff   <= FILT_NONE;
      end else begin
         column_ff <= column_in;
         first_ff  <= first_in;
         failed_ff <= failed_in;
         kind_ff   <= kind_in;
      end
   end

endmodule

FILE: rtl/psu_fifo.sv
// Short request queue between the unfilter front end and back end.
// Depends on psu_pkg only through the importing convention of the project.
module psu_fifo
   import psu_pkg::*;
#(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/psu_back.sv
// Back end of the unfilter: line buffer, left/up-left history, predictor, output register.
// Depends on psu_pkg (item type, filter codes, avg_pick, paeth_pick).
module psu_back
   import psu_pkg::*;
#(
   parameter int ADDR_W          = 12,
   parameter int BPP_W           = 3,
   parameter int MAX_ROW_BYTES   = 4096,
   parameter int MAX_PIXEL_BYTES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [BPP_W-1:0]  bpp_eff,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic [ADDR_W-1:0] q_x,
   input  psu_item_type      q_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_pixel_byte,
   output logic              rsp_end_of_row,
   output logic              rsp_bad_filter
);

   localparam int HIDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   logic [7:0]        line_mem [MAX_ROW_BYTES];
   logic [7:0]        rd_ff;
   logic              byp_ff;
   logic [7:0]        byp_data_ff;

   logic              r_valid_ff;
   psu_item_type      r_item_ff;
   logic [ADDR_W-1:0] r_x_ff;

   logic [7:0]        left_ff   [MAX_PIXEL_BYTES];
   logic [7:0]        upleft_ff [MAX_PIXEL_BYTES];

   logic              out_valid_ff;
   logic [7:0]        out_pixel_ff;
   logic              out_eor_ff;
   logic              out_bad_ff;

   logic              adv;
   logic [HIDX_W-1:0] hidx;
   logic              has_left;
   logic [7:0]        mem_b;
   logic [7:0]        a, b, c;
   logic [7:0]        pred;
   logic [7:0]        res;

   assign adv   = r_valid_ff && (!out_valid_ff || rsp_ready);
   assign q_pop = !q_empty && (!r_valid_ff || adv);

   always_comb begin
      hidx     = HIDX_W'(bpp_eff - 1'b1);
      has_left = 32'(r_x_ff) >= 32'(bpp_eff);
      mem_b    = byp_ff ? byp_data_ff : rd_ff;
      b        = r_item_ff.first_row ? 8'd0 : mem_b;
      a        = has_left ? left_ff[hidx] : 8'd0;
      c        = (!r_item_ff.first_row && has_left) ? upleft_ff[hidx] : 8'd0;
      case (r_item_ff.kind)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = avg_pick(a, b);
         FILT_PAETH: pred = paeth_pick(a, b, c);
         default:    pred = 8'd0;
      endcase
      res = r_item_ff.data + pred;
   end

   // line buffer: write the finished byte, read the next one's byte above
   always_ff @(posedge clock) begin
      if (adv) begin
         line_mem[r_x_ff] <= res;
      end
      if (q_pop) begin
         rd_ff <= line_mem[q_x];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= q_pop | (r_valid_ff & !adv);
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         r_item_ff   <= q_item;
         r_x_ff      <= q_x;
         // forward a same-edge write to the same column
         byp_ff      <= adv && (r_x_ff == q_x);
         byp_data_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
            left_ff[i]   <= left_ff[i-1];
            upleft_ff[i] <= upleft_ff[i-1];
         end
         left_ff[0]   <= res;
         upleft_ff[0] <= b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_pixel_ff <= r_item_ff.failed ? 8'd0 : res;
         out_eor_ff   <= r_item_ff.last;
         out_bad_ff   <= r_item_ff.failed;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_byte = out_pixel_ff;
   assign rsp_end_of_row = out_eor_ff;
   assign rsp_bad_filter = out_bad_ff;

endmodule

FILE: rtl/png_scanline_unfilter.sv
// Top level of the PNG 8-bit scanline unfilter (None/Sub/Up/Average/Paeth).
// Depends on psu_pkg, psu_front, psu_fifo and psu_back.
//
//  channel  | ports                                         | direction
//  ---------+-----------------------------------------------+----------
//  req      | req_valid/ready, data_byte, start_of_image    | in
//  rsp      | rsp_valid/ready, pixel_byte, end_of_row, bad  | out
//  csr      | csr_valid/ready, csr_index, csr_wdata         | in
//
// One request per cycle sustained while rsp_ready holds; a pixel byte passes the
// queue slot, the line buffer read stage, then the output register to reach rsp.
// Filter bytes give no response. The left-neighbor loop closes in the back
// end's compute stage.
// Reset is synchronous; the line buffer is not cleared and holds garbage until
// written. The four-entry queue lets req keep flowing while rsp stalls briefly.
module png_scanline_unfilter
   import psu_pkg::*;
#(
   parameter int MAX_ROW_BYTES   = 4096,
   parameter int MAX_PIXEL_BYTES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_start_of_image,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_pixel_byte,
   output logic                  rsp_end_of_row,
   output logic                  rsp_bad_filter,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
   localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int BPP_W  = $clog2(MAX_PIXEL_BYTES + 1);
   localparam int Q_W    = ADDR_W + $bits(psu_item_type);

   // configuration registers
   logic [BPP_REG_W-1:0]  bpp_ff, bpp_in;
   logic [CSR_DATA_W-1:0] row_len_ff, row_len_in;
   logic [BPP_W-1:0]      bpp_eff;
   logic [LEN_W-1:0]      len_eff;

   // front to queue
   logic                  q_push;
   logic [ADDR_W-1:0]     q_x_in;
   psu_item_type          q_item_in;
   logic                  q_full;

   // queue to back
   logic                  q_pop;
   logic                  q_empty;
   logic [Q_W-1:0]        q_rd_data;
   logic [ADDR_W-1:0]     q_x_out;
   psu_item_type          q_item_out;

   assign csr_ready = 1'b1;

   // take register writes; unknown indexes are dropped
   always_comb begin
      bpp_in     = bpp_ff;
      row_len_in = row_len_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BPP:     bpp_in     = csr_wdata[BPP_REG_W-1:0];
            CSR_ROW_LEN: row_len_in = csr_wdata;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff     <= BPP_REG_W'(1);
         row_len_ff <= CSR_DATA_W'(1);
      end else begin
         bpp_ff     <= bpp_in;
         row_len_ff <= row_len_in;
      end
   end

   // clamp register values into their working ranges
   always_comb begin
      if (bpp_ff == '0) begin
         bpp_eff = BPP_W'(1);
      end else if (32'(bpp_ff) > 32'(MAX_PIXEL_BYTES)) begin
         bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
      end else begin
         bpp_eff = BPP_W'(bpp_ff);
      end
      if (row_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(row_len_ff) > 32'(MAX_ROW_BYTES)) begin
         len_eff = LEN_W'(MAX_ROW_BYTES);
      end else begin
         len_eff = LEN_W'(row_len_ff);
      end
   end

   psu_front #(
      .LEN_W  (LEN_W),
      .ADDR_W (ADDR_W)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_start_of_image (req_start_of_image),
      .len_eff            (len_eff),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_x                (q_x_in),
      .q_item             (q_item_in)
   );

   psu_fifo #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data ({q_x_in, q_item_in}),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty),
      .full    (q_full)
   );

   assign q_x_out    = q_rd_data[Q_W-1 -: ADDR_W];
   assign q_item_out = psu_item_type'(q_rd_data[$bits(psu_item_type)-1:0]);

   psu_back #(
      .ADDR_W          (ADDR_W),
      .BPP_W           (BPP_W),
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .bpp_eff        (bpp_eff),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_x            (q_x_out),
      .q_item         (q_item_out),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_end_of_row (rsp_end_of_row),
      .rsp_bad_filter (rsp_bad_filter)
   );

   // a start-of-image byte is always a filter byte and never reaches the queue
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_start_of_image) |-> !q_push)
      else $error("start-of-image byte was queued as a pixel");

   // the front end never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue overflow");

   // an error response carries a zero pixel
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_filter) |-> (rsp_pixel_byte == 8'd0))
      else $error("bad filter response with nonzero pixel");

   // the back end never pops an empty queue
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue underflow");

endmodule
